FILE: sv/ttg_pkg.sv
package ttg_pkg;

	localparam int CLK_W    = 24;
	localparam int TPM_W    = 16;
	localparam int FREQ_W   = 16;
	localparam int DUR_IN_W = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CLK_W-1:0] TIMER_CLOCK_RESET  = 24'd4000000;
	localparam logic [TPM_W-1:0] TICKS_PER_MS_RESET = 16'd4000;

	localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 1'b1;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam int DIV_STEPS = CLK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic              cmd;
		logic [FREQ_W-1:0] freq_hz;
		logic [DUR_IN_W-1:0] duration_ms;
	} in_item_t;

	typedef struct packed {
		logic tone_level;
		logic tone_enabled;
		logic playing;
		logic start_rejected;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

FILE: sv/ttg_divider.sv
module ttg_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ttg_pkg::CLK_W-1:0]  dividend,
	input  logic [ttg_pkg::FREQ_W-1:0] divisor,
	output ttg_pkg::div_status_t       status,
	output logic [ttg_pkg::CLK_W-1:0]  quotient
);
	import ttg_pkg::*;

	logic [FREQ_W-1:0]    rem_q;
	logic [CLK_W-1:0]     quo_q;
	logic [FREQ_W-1:0]    divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [FREQ_W:0]      trial;
	logic [FREQ_W:0]      diff;

	always_comb begin
		trial = {rem_q, quo_q[CLK_W-1]};
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			if (!diff[FREQ_W]) begin
				rem_q <= diff[FREQ_W-1:0];
				quo_q <= {quo_q[CLK_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[FREQ_W-1:0];
				quo_q <= {quo_q[CLK_W-2:0], 1'b0};
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

FILE: sv/timed_tone_generator_core.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_data (cmd, freq_hz, duration_ms)
// out     | output    | out_valid/out_stall | out_data (level, enabled, playing, rejected)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A tick item, and a rejected start, each leave one result item.
// An accepted start runs the restoring divider, one quotient bit a cycle, then hands
// over the quotient in ST_WAIT and commits it once the output register is free; the
// input is stalled from the accepted start until the commit.
// Reset is asynchronous and restores the register defaults and a silent output.
// The output register frees the input side; a stalled result holds the next item off.
module timed_tone_generator_core #(
	parameter int DURATION_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ttg_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ttg_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [ttg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttg_pkg::CFG_W-1:0]     cfg_data
);
	import ttg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]                state_q;
	logic [CLK_W-1:0]          timer_clock_q;
	logic [TPM_W-1:0]          tpm_q;
	logic [CLK_W-1:0]          half_period_q;
	logic [CLK_W-1:0]          tone_countdown_q;
	logic [DURATION_WIDTH-1:0] duration_left_q;
	logic [TPM_W-1:0]          ms_countdown_q;
	logic                      pin_q;
	logic                      active_q;
	logic [DUR_IN_W-1:0]       dur_q;
	logic                      out_valid_q;
	out_item_t                 out_data_q;

	logic                      out_free;
	logic                      accept;
	logic                      tick_acc;
	logic                      start_acc;
	logic                      reject;
	logic                      div_start;
	logic                      commit;
	div_status_t               div_st;
	logic [CLK_W-1:0]          quotient;
	logic [CLK_W-1:0]          hp;
	logic [DURATION_WIDTH-1:0] dur_sat;

	logic [CLK_W-1:0]          tc_n;
	logic                      pin_n;
	logic [TPM_W-1:0]          ms_n;
	logic [DURATION_WIDTH-1:0] dl_n;
	logic                      act_n;

	ttg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (timer_clock_q),
		.divisor  (in_data.freq_hz),
		.status   (div_st),
		.quotient (quotient)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign tick_acc  = accept && (in_data.cmd == CMD_TICK);
	assign start_acc = accept && (in_data.cmd == CMD_START);
	assign reject    = start_acc && (active_q || (in_data.freq_hz == '0));
	assign div_start = start_acc && !reject;
	assign commit    = (state_q == ST_WAIT) && out_free;

	assign hp = ((quotient >> 1) == '0) ? CLK_W'(1) : (quotient >> 1);

	generate
		if (DURATION_WIDTH >= DUR_IN_W) begin : g_dur_wide
			assign dur_sat = DURATION_WIDTH'(dur_q);
		end else begin : g_dur_narrow
			assign dur_sat = (|dur_q[DUR_IN_W-1:DURATION_WIDTH]) ? '1
			                                                     : dur_q[DURATION_WIDTH-1:0];
		end
	endgenerate

	always_comb begin
		tc_n  = tone_countdown_q;
		pin_n = pin_q;
		ms_n  = ms_countdown_q;
		dl_n  = duration_left_q;
		act_n = active_q;
		if (active_q) begin
			if (tone_countdown_q <= CLK_W'(1)) begin
				pin_n = !pin_q;
				tc_n  = half_period_q;
			end else begin
				tc_n = tone_countdown_q - 1'b1;
			end
		end
		if (ms_countdown_q == '0) begin
			ms_n = (tpm_q == '0) ? '0 : tpm_q - 1'b1;
			if (duration_left_q != '0) begin
				dl_n = duration_left_q - 1'b1;
			end else begin
				act_n = 1'b0;
			end
		end else begin
			ms_n = ms_countdown_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			timer_clock_q    <= TIMER_CLOCK_RESET;
			tpm_q            <= TICKS_PER_MS_RESET;
			half_period_q    <= '0;
			tone_countdown_q <= '0;
			duration_left_q  <= '0;
			ms_countdown_q   <= '0;
			pin_q            <= 1'b0;
			active_q         <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMER_CLOCK:  timer_clock_q <= cfg_data;
					REG_TICKS_PER_MS: tpm_q         <= cfg_data[TPM_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (div_start) state_q <= ST_DIV;
				ST_DIV:  if (div_st.done) state_q <= ST_WAIT;
				ST_WAIT: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (tick_acc) begin
				tone_countdown_q <= tc_n;
				pin_q            <= pin_n;
				ms_countdown_q   <= ms_n;
				duration_left_q  <= dl_n;
				active_q         <= act_n;
			end else if (commit) begin
				half_period_q    <= hp;
				tone_countdown_q <= hp;
				duration_left_q  <= dur_sat;
				active_q         <= 1'b1;
			end
			if (tick_acc || reject || commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dur_q <= in_data.duration_ms;
		end
		if (tick_acc) begin
			out_data_q <= '{tone_level: pin_n, tone_enabled: act_n, playing: act_n,
			                start_rejected: 1'b0};
		end else if (reject) begin
			out_data_q <= '{tone_level: pin_q, tone_enabled: active_q, playing: active_q,
			                start_rejected: 1'b1};
		end else if (commit) begin
			out_data_q <= '{tone_level: pin_q, tone_enabled: 1'b1, playing: 1'b1,
			                start_rejected: 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while a start is in progress");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the division state");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_st.busy)
		else $error("divider busy while the sequencer is idle");

	a_active_period: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (half_period_q != '0))
		else $error("tone active with a zero half period");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (out_valid && out_data.playing && active_q))
		else $error("committed start did not leave a playing result");

endmodule
